[hdl/sus_pkg.sv]
// sus_pkg: shared types and codes for the sorted unique set
// no dependencies; used by the interfaces, the cells, the top level and the checker
`default_nettype none

package sus_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STATUS_W = 2;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [1:0]          cmd_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;

  localparam cmd_t CMD_HOLD   = 2'd0;
  localparam cmd_t CMD_INSERT = 2'd1;
  localparam cmd_t CMD_REMOVE = 2'd2;
  localparam cmd_t CMD_DRAIN  = 2'd3;

  typedef struct packed {
    cmd_t cmd;
  } cell_ctrl_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

`default_nettype wire

[hdl/sus_if.sv]
// sus_in_if, sus_out_if: request and result channels with valid/ready handshake
// depends on sus_pkg
`default_nettype none

interface sus_in_if;
  logic              valid;
  logic              ready;
  sus_pkg::op_t      op;
  logic [sus_pkg::KEY_W-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface sus_out_if;
  logic              valid;
  logic              ready;
  sus_pkg::status_t  status;
  logic [sus_pkg::KEY_W-1:0] drained_value;
  logic              drained_valid;
  logic              last;

  modport source (output valid, output status, output drained_value,
                  output drained_valid, output last, input ready);
  modport sink   (input valid, input status, input drained_value,
                  input drained_valid, input last, output ready);
endinterface

`default_nettype wire

[hdl/sorted_unique_set_top.sv]
// sorted_unique_set_top: sorted set of unique values on a chain of compare-and-shift cells
// depends on sus_pkg, sus_if (sus_in_if, sus_out_if) and sus_cell
//
//   channel   direction  fields                                      handshake
//   in_req    sink       op, key                                     valid/ready
//   out_rsp   source     status, drained_value, drained_valid, last  valid/ready
//
// insert and remove: every cell compares against the key at once and the chain shifts at
// the edge that takes the request; the result is registered
// a clear gives one result per held value (one empty if none), one a cycle, shifting
// the chain left towards cell 0; no request is taken until the last of them is registered
// a stalled result holds the output register and the chain; reset empties the set
`default_nettype none

module sorted_unique_set_top #(
  parameter int unsigned CAPACITY    = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sus_in_if.sink     in_req,
  sus_out_if.source  out_rsp
);

  localparam int unsigned CW = (VALUE_WIDTH < sus_pkg::KEY_W) ? VALUE_WIDTH : sus_pkg::KEY_W;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                    state_r, state_nxt;
  logic [VALUE_WIDTH-1:0]  key;
  sus_pkg::cell_ctrl_t     ctrl;
  sus_pkg::cell_flags_t    flags [CAPACITY];
  logic [VALUE_WIDTH-1:0]  cell_val [CAPACITY];
  logic [CAPACITY-1:0]     occ_vec;
  logic [CAPACITY-1:0]     lt_vec;
  logic [CAPACITY-1:0]     eq_vec;
  logic                    hit;
  logic                    full;
  logic                    slot_free;
  logic                    acc;

  logic                    load;
  sus_pkg::status_t        res_status;
  logic [sus_pkg::KEY_W-1:0] res_value;
  logic                    res_valid;
  logic                    res_last;

  logic                    out_valid_r, out_valid_nxt;
  sus_pkg::status_t        status_r;
  logic [sus_pkg::KEY_W-1:0] value_r;
  logic                    dvalid_r;
  logic                    last_r;

  assign key = VALUE_WIDTH'(in_req.key[CW-1:0]);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   left_lt;
    logic [VALUE_WIDTH-1:0] left_val;
    logic                   left_occ;
    logic [VALUE_WIDTH-1:0] right_val;
    logic                   right_occ;

    if (i == 0) begin : g_head
      assign left_lt  = 1'b1;
      assign left_val = key;
      assign left_occ = 1'b0;
    end else begin : g_body
      assign left_lt  = lt_vec[i-1];
      assign left_val = cell_val[i-1];
      assign left_occ = occ_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = cell_val[i];
      assign right_occ = 1'b0;
    end else begin : g_mid
      assign right_val = cell_val[i+1];
      assign right_occ = occ_vec[i+1];
    end

    sus_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .key       (key),
      .left_lt   (left_lt),
      .left_val  (left_val),
      .left_occ  (left_occ),
      .right_val (right_val),
      .right_occ (right_occ),
      .flags     (flags[i]),
      .val       (cell_val[i]),
      .occ       (occ_vec[i])
    );

    assign lt_vec[i] = flags[i].lt;
    assign eq_vec[i] = flags[i].eq;
  end

  assign hit       = |eq_vec;
  assign full      = occ_vec[CAPACITY-1];
  assign slot_free = !out_valid_r || out_rsp.ready;
  assign in_req.ready = (state_r == ST_IDLE) && slot_free;
  assign acc       = in_req.valid && in_req.ready;

  always_comb begin
    ctrl.cmd   = sus_pkg::CMD_HOLD;
    load       = 1'b0;
    res_status = sus_pkg::ST_OK;
    res_value  = '0;
    res_valid  = 1'b0;
    res_last   = 1'b1;
    state_nxt  = state_r;
    if (state_r == ST_DRAIN) begin
      if (slot_free) begin
        ctrl.cmd  = sus_pkg::CMD_DRAIN;
        load      = 1'b1;
        res_value = sus_pkg::KEY_W'(cell_val[0][CW-1:0]);
        res_valid = 1'b1;
        res_last  = !occ_vec[1];
        if (!occ_vec[1]) begin
          state_nxt = ST_IDLE;
        end
      end
    end else if (acc) begin
      load = 1'b1;
      unique case (in_req.op)
        sus_pkg::OP_INSERT: begin
          if (hit) begin
            res_status = sus_pkg::ST_OK;
          end else if (full) begin
            res_status = sus_pkg::ST_FULL;
          end else begin
            ctrl.cmd = sus_pkg::CMD_INSERT;
          end
        end
        sus_pkg::OP_REMOVE: begin
          if (hit) begin
            ctrl.cmd = sus_pkg::CMD_REMOVE;
          end else begin
            res_status = sus_pkg::ST_NOT_FOUND;
          end
        end
        sus_pkg::OP_CLEAR: begin
          if (occ_vec[0]) begin
            ctrl.cmd  = sus_pkg::CMD_DRAIN;
            res_value = sus_pkg::KEY_W'(cell_val[0][CW-1:0]);
            res_valid = 1'b1;
            res_last  = !occ_vec[1];
            state_nxt = occ_vec[1] ? ST_DRAIN : ST_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= res_status;
      value_r  <= res_value;
      dvalid_r <= res_valid;
      last_r   <= res_last;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = status_r;
  assign out_rsp.drained_value = value_r;
  assign out_rsp.drained_valid = dvalid_r;
  assign out_rsp.last          = last_r;

endmodule

`default_nettype wire

[hdl/sus_cell.sv]
// sus_cell: one slot of the sorted chain, holds a value and an occupied flag
// depends on sus_pkg
`default_nettype none

module sus_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire sus_pkg::cell_ctrl_t     ctrl,
  input  wire logic [VALUE_WIDTH-1:0]  key,
  input  wire logic                    left_lt,
  input  wire logic [VALUE_WIDTH-1:0]  left_val,
  input  wire logic                    left_occ,
  input  wire logic [VALUE_WIDTH-1:0]  right_val,
  input  wire logic                    right_occ,
  output sus_pkg::cell_flags_t         flags,
  output logic [VALUE_WIDTH-1:0]       val,
  output logic                         occ
);

  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                   occ_r, occ_nxt;

  always_comb begin
    flags.lt = occ_r && (val_r < key);
    flags.eq = occ_r && (val_r == key);
  end

  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    unique case (ctrl.cmd)
      sus_pkg::CMD_INSERT: begin
        if (!flags.lt) begin
          if (left_lt) begin
            val_nxt = key;
            occ_nxt = 1'b1;
          end else begin
            val_nxt = left_val;
            occ_nxt = left_occ;
          end
        end
      end
      sus_pkg::CMD_REMOVE: begin
        if (!flags.lt) begin
          val_nxt = right_val;
          occ_nxt = right_occ;
        end
      end
      sus_pkg::CMD_DRAIN: begin
        val_nxt = right_val;
        occ_nxt = right_occ;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign occ = occ_r;

endmodule

`default_nettype wire

[hdl/sus_checker.sv]
// sus_checker: port-level checks on the sorted unique set, bound to the top level
// depends on sus_pkg and sorted_unique_set_top
`default_nettype none

module sus_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire sus_pkg::op_t               in_op,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire sus_pkg::status_t           out_status,
  input wire logic [sus_pkg::KEY_W-1:0]  out_drained_value,
  input wire logic                       out_drained_valid,
  input wire logic                       out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_drained_value) && $stable(out_drained_valid) && $stable(out_last))
    else $error("result changed while stalled");

  // insert, remove and unused codes answer on the next cycle with one final result
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op != sus_pkg::OP_CLEAR)
      |=> out_valid && out_last && !out_drained_valid)
    else $error("single request gave no final result");

  // a result without a value is always final and carries zero
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_drained_valid |-> out_last && (out_drained_value == '0))
    else $error("empty result not final");

  // drained values always report success
  a_drain_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drained_valid |-> out_status == sus_pkg::ST_OK)
    else $error("drained value with bad status");

endmodule

bind sorted_unique_set_top sus_checker u_sus_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_req.valid),
  .in_ready          (in_req.ready),
  .in_op             (in_req.op),
  .out_valid         (out_rsp.valid),
  .out_ready         (out_rsp.ready),
  .out_status        (out_rsp.status),
  .out_drained_value (out_rsp.drained_value),
  .out_drained_valid (out_rsp.drained_valid),
  .out_last          (out_rsp.last)
);

`default_nettype wire

[sim/tb_sorted_unique_set_top.sv]
// tb_sorted_unique_set_top: self-checking bench for the sorted unique set
// depends on sus_pkg, sus_if and sorted_unique_set_top; requests and results move with
// random gaps, every result is predicted from a local copy of the set and checked in order
`default_nettype none

module tb_sorted_unique_set_top;

  localparam int unsigned CAPACITY    = 32;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned NUM_REQS    = 280;
  localparam int unsigned MAX_WAIT    = 18;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned POOL_DEPTH  = 24;
  localparam sus_pkg::op_t OP_SPARE = 2'd3;
  localparam logic [sus_pkg::KEY_W-1:0] VALUE_MASK =
    {sus_pkg::KEY_W{1'b1}} >> (sus_pkg::KEY_W - VALUE_WIDTH);

  typedef logic [sus_pkg::KEY_W-1:0] key_t;

  typedef struct packed {
    sus_pkg::op_t op;
    key_t         key;
  } set_req_t;

  typedef struct packed {
    sus_pkg::status_t status;
    key_t             value;
    logic             valid;
    logic             last;
  } set_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  sus_in_if  req_if();
  sus_out_if rsp_if();

  sorted_unique_set_top #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if),
    .out_rsp (rsp_if)
  );

  always #5 clk = ~clk;

  set_req_t    req_backlog[$];
  set_rsp_t    awaited_rsp[$];
  key_t        held_keys[$];
  key_t        key_pool[$];
  int          fail_count = 0;
  int unsigned reqs_accepted = 0;
  int unsigned quiet_cycles;
  logic [4:0]  req_gap;
  logic [4:0]  rsp_hold;
  bit          req_burst = 1'b0;
  bit          rsp_burst = 1'b0;

  function automatic logic [4:0] draw_wait(input bit burst);
    if (burst) return 5'd0;
    return 5'($urandom_range(0, MAX_WAIT));
  endfunction

  // ascending set with unique entries, as the chain should hold it
  task automatic apply_set_request(input sus_pkg::op_t op, input key_t raw_key);
    key_t        key;
    int unsigned pos;
    bit          hit;
    set_rsp_t    rsp;
    key = raw_key & VALUE_MASK;
    rsp.status = sus_pkg::ST_OK;
    rsp.value  = '0;
    rsp.valid  = 1'b0;
    rsp.last   = 1'b1;
    pos = 0;
    while (pos < held_keys.size() && held_keys[pos] < key) pos++;
    hit = (pos < held_keys.size()) && (held_keys[pos] == key);
    unique case (op)
      sus_pkg::OP_INSERT: begin
        if (!hit) begin
          if (held_keys.size() >= CAPACITY) rsp.status = sus_pkg::ST_FULL;
          else held_keys.insert(pos, key);
        end
        awaited_rsp.push_back(rsp);
      end
      sus_pkg::OP_REMOVE: begin
        if (hit) held_keys.delete(pos);
        else rsp.status = sus_pkg::ST_NOT_FOUND;
        awaited_rsp.push_back(rsp);
      end
      sus_pkg::OP_CLEAR: begin
        if (held_keys.size() == 0) awaited_rsp.push_back(rsp);
        foreach (held_keys[i]) begin
          rsp.value = held_keys[i];
          rsp.valid = 1'b1;
          rsp.last  = (i == held_keys.size() - 1);
          awaited_rsp.push_back(rsp);
        end
        held_keys.delete();
      end
      default: begin
        awaited_rsp.push_back(rsp);
      end
    endcase
  endtask

  task automatic queue_req(input sus_pkg::op_t op, input key_t key);
    set_req_t req;
    req.op  = op;
    req.key = key;
    req_backlog.push_back(req);
    if (op == sus_pkg::OP_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
    end
  endtask

  // recent keys give hits and duplicates, the rest are fresh or extreme
  function automatic key_t pick_key(input int unsigned reuse_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < reuse_pct && key_pool.size() != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (roll >= 96) return roll[0] ? '0 : '1;
    return $urandom;
  endfunction

  always @(posedge clk) begin : req_driver
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      req_gap <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        apply_set_request(req_if.op, req_if.key);
        reqs_accepted++;
      end
      if ($urandom_range(0, 31) == 0) req_burst <= ~req_burst;
      if (!req_if.valid || req_if.ready) begin
        if (req_gap != 0) begin
          req_if.valid <= 1'b0;
          req_gap <= req_gap - 1'b1;
        end else if (req_backlog.size() != 0) begin
          req_if.valid <= 1'b1;
          req_if.op <= req_backlog[0].op;
          req_if.key <= req_backlog[0].key;
          void'(req_backlog.pop_front());
          req_gap <= draw_wait(req_burst);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rsp_checker
    logic [4:0] hold_next;
    set_rsp_t   want;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      rsp_hold <= '0;
    end else begin
      hold_next = rsp_hold;
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_rsp.size() == 0) begin
          $error("unexpected result: status %0d value %h valid %0d last %0d",
                 rsp_if.status, rsp_if.drained_value, rsp_if.drained_valid, rsp_if.last);
          fail_count++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.status);
            fail_count++;
          end
          if (rsp_if.drained_value !== want.value) begin
            $error("drained_value: expected %h, got %h", want.value, rsp_if.drained_value);
            fail_count++;
          end
          if (rsp_if.drained_valid !== want.valid) begin
            $error("drained_valid: expected %0d, got %0d", want.valid, rsp_if.drained_valid);
            fail_count++;
          end
          if (rsp_if.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, rsp_if.last);
            fail_count++;
          end
        end
        hold_next = draw_wait(rsp_burst);
      end else if (hold_next != 0) begin
        hold_next = hold_next - 1'b1;
      end
      if ($urandom_range(0, 31) == 0) rsp_burst <= ~rsp_burst;
      rsp_hold <= hold_next;
      rsp_if.ready <= (hold_next == 0);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[sorted_unique_set_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned roll;
    int unsigned n_reqs;
    bit          first_run;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.op = sus_pkg::OP_INSERT;
    req_if.key = '0;
    rsp_if.ready = 1'b0;

    // empty store, spare op code, extremes, duplicates, misses, drains
    queue_req(sus_pkg::OP_CLEAR, '0);
    queue_req(sus_pkg::OP_REMOVE, 32'd5);
    queue_req(OP_SPARE, '1);
    queue_req(sus_pkg::OP_INSERT, 32'h8000_0000);
    queue_req(sus_pkg::OP_INSERT, '0);
    queue_req(sus_pkg::OP_INSERT, '1);
    queue_req(sus_pkg::OP_INSERT, '0);
    queue_req(sus_pkg::OP_INSERT, 32'h7FFF_FFFF);
    queue_req(sus_pkg::OP_REMOVE, 32'd1);
    queue_req(sus_pkg::OP_REMOVE, '0);
    queue_req(sus_pkg::OP_INSERT, 32'h5555_5555);
    queue_req(sus_pkg::OP_INSERT, 32'hAAAA_AAAA);
    queue_req(OP_SPARE, 32'h1234_5678);
    queue_req(sus_pkg::OP_CLEAR, '1);
    queue_req(sus_pkg::OP_INSERT, 32'd42);
    queue_req(sus_pkg::OP_REMOVE, 32'd42);
    queue_req(sus_pkg::OP_REMOVE, 32'd42);
    queue_req(sus_pkg::OP_REMOVE, '1);
    queue_req(sus_pkg::OP_CLEAR, 32'hDEAD_BEEF);

    // fill runs push the store to full, mixed runs hit and miss around it
    first_run = 1'b1;
    while (req_backlog.size() < NUM_REQS) begin
      if (first_run || $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(34, 44)) queue_req(sus_pkg::OP_INSERT, pick_key(8));
        repeat ($urandom_range(1, 3)) queue_req(sus_pkg::OP_INSERT, pick_key(50));
        if ($urandom_range(0, 3) != 0) queue_req(sus_pkg::OP_CLEAR, $urandom);
      end else begin
        repeat ($urandom_range(8, 30)) begin
          roll = $urandom_range(0, 19);
          if (roll < 9) queue_req(sus_pkg::OP_INSERT, pick_key(40));
          else if (roll < 16) queue_req(sus_pkg::OP_REMOVE, pick_key(75));
          else if (roll < 18) queue_req(sus_pkg::OP_CLEAR, $urandom);
          else queue_req(OP_SPARE, $urandom);
        end
      end
      first_run = 1'b0;
    end
    n_reqs = req_backlog.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_accepted < n_reqs) @(posedge clk);
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[sorted_unique_set_top] OK");
    end else begin
      $display("[sorted_unique_set_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hdl/sus_pkg.sv
hdl/sus_if.sv
hdl/sus_cell.sv
hdl/sorted_unique_set_top.sv
hdl/sus_checker.sv
sim/tb_sorted_unique_set_top.sv
